### sv/tbv_pkg.sv
// shared types and constants of the text bytecode validator
package tbv_pkg;

    // status codes of a result word
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_VALID   = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_BRANCH  = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;
    localparam logic [2:0] ST_GLYPH   = 3'd5;
    localparam logic [2:0] ST_NOTERM  = 3'd6;
    localparam logic [2:0] ST_BUDGET  = 3'd7;

    // configuration register indexes
    localparam logic CFG_CUSTOM_COUNT = 1'b0;
    localparam logic CFG_BYTE_BUDGET  = 1'b1;

    // opcode boundaries and special opcodes
    localparam logic [7:0] OP_TERM       = 8'h00;
    localparam logic [7:0] OP_GLYPH_MIN  = 8'h20;
    localparam logic [7:0] OP_LAST_KNOWN = 8'd26;
    localparam logic [7:0] OP_BRANCH_A   = 8'd8;
    localparam logic [7:0] OP_BRANCH_B   = 8'd9;
    localparam logic [7:0] OP_LEN3       = 8'd5;
    localparam logic [7:0] OP_LEN4       = 8'd12;
    localparam logic [7:0] OP_LEN5_A     = 8'd6;
    localparam logic [7:0] OP_LEN5_B     = 8'd7;
    localparam logic [7:0] OP_LEN5_C     = 8'd10;
    localparam logic [7:0] OP_LEN5_D     = 8'd14;

    // glyph index bases
    localparam logic [15:0] GLYPH_BUILTIN_BASE = 16'h2000;
    localparam logic [15:0] GLYPH_CUSTOM_BASE  = 16'h4000;

    // byte total and budget
    localparam int unsigned TOTAL_W = 23;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
    localparam logic [TOTAL_W-1:0] BUDGET_RESET = 23'd4194304;

    // opcode class found by the front
    typedef enum logic [2:0] {
        K_TERM,
        K_GLYPH,
        K_PLAIN,
        K_UNKNOWN,
        K_BRANCH
    } t_kind;

    // classified word passed from front to back
    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_of_string;
        logic       first_of_archive;
        t_kind      kind;
        logic [2:0] extra_bytes;
    } t_item;

    // configuration values held by the back
    typedef struct packed {
        logic [15:0]        custom_glyph_count;
        logic [TOTAL_W-1:0] byte_budget;
    } t_cfg;

endpackage

### sv/tbv_front.sv
// front: accepts input words and classifies the opcode byte
module tbv_front (
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,
    input  logic                 i_s_tlast,
    input  logic                 i_s_tuser,
    input  logic                 i_full,
    output logic                 o_push,
    output tbv_pkg::t_item       o_item
);

    tbv_pkg::t_kind w_kind;
    logic [2:0]     w_extra;

    // accept whenever the queue has room
    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

    // opcode class and bytes still owed after the opcode
    always_comb begin
        w_extra = 3'd0;
        if (i_s_tdata == tbv_pkg::OP_TERM) begin
            w_kind = tbv_pkg::K_TERM;
        end else if (i_s_tdata >= tbv_pkg::OP_GLYPH_MIN) begin
            w_kind = tbv_pkg::K_GLYPH;
        end else if (i_s_tdata > tbv_pkg::OP_LAST_KNOWN) begin
            w_kind = tbv_pkg::K_UNKNOWN;
        end else if (i_s_tdata == tbv_pkg::OP_BRANCH_A || i_s_tdata == tbv_pkg::OP_BRANCH_B) begin
            w_kind = tbv_pkg::K_BRANCH;
        end else begin
            w_kind = tbv_pkg::K_PLAIN;
            case (i_s_tdata) inside
                tbv_pkg::OP_LEN3: w_extra = 3'd2;
                tbv_pkg::OP_LEN4: w_extra = 3'd3;
                tbv_pkg::OP_LEN5_A, tbv_pkg::OP_LEN5_B,
                tbv_pkg::OP_LEN5_C, tbv_pkg::OP_LEN5_D: w_extra = 3'd4;
                default: w_extra = 3'd0;
            endcase
        end
    end

    // pack the classified word
    always_comb begin
        o_item.code_byte        = i_s_tdata;
        o_item.last_of_string   = i_s_tlast;
        o_item.first_of_archive = i_s_tuser;
        o_item.kind             = w_kind;
        o_item.extra_bytes      = w_extra;
    end

endmodule

### sv/tbv_fifo.sv
// queue of classified words between front and back
module tbv_fifo #(
    parameter int unsigned DEPTH_LOG2 = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tbv_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output tbv_pkg::t_item o_item,
    input  logic           i_pop
);

    localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

    tbv_pkg::t_item           r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0]    r_wr_ptr;
    logic [DEPTH_LOG2-1:0]    r_rd_ptr;
    logic [DEPTH_LOG2:0]      r_count;
    logic [DEPTH_LOG2-1:0]    n_wr_ptr;
    logic [DEPTH_LOG2-1:0]    n_rd_ptr;
    logic [DEPTH_LOG2:0]      n_count;
    logic                     w_push;
    logic                     w_pop;

    assign o_full  = (r_count == (DEPTH_LOG2+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### sv/tbv_back.sv
// back: parse state, byte budget, sticky error and result register
module tbv_back #(
    parameter int unsigned BUILTIN_GLYPHS = 287
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [22:0]    i_cfg_data,
    input  logic           i_q_valid,
    input  tbv_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [7:0]     o_m_tdata,
    output logic           o_m_tlast
);

    localparam logic [15:0] LP_BUILTIN = 16'(BUILTIN_GLYPHS);

    tbv_pkg::t_cfg                 r_cfg;
    logic [2:0]                    r_left;
    logic                          r_pend;
    logic [7:0]                    r_high;
    logic                          r_seen;
    logic [2:0]                    r_err;
    logic [tbv_pkg::TOTAL_W-1:0]   r_total;
    logic                          r_valid;
    logic [2:0]                    r_status;
    logic                          r_last;

    logic [2:0]                    n_left;
    logic                          n_pend;
    logic [7:0]                    n_high;
    logic                          n_seen;
    logic [2:0]                    n_err;
    logic [tbv_pkg::TOTAL_W-1:0]   n_total;
    logic [2:0]                    n_status;

    logic [15:0]                   w_glyph;
    logic                          w_glyph_ok;

    // take the queue head when the result register is free or draining
    assign o_q_pop    = i_q_valid && (!r_valid || i_m_tready);
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {5'd0, r_status};
    assign o_m_tlast  = r_last;

    // glyph range check on the pending high byte and this byte
    always_comb begin
        w_glyph = {r_high, i_q_item.code_byte};
        if (w_glyph < tbv_pkg::GLYPH_CUSTOM_BASE) begin
            w_glyph_ok = (w_glyph >= tbv_pkg::GLYPH_BUILTIN_BASE)
                      && ((w_glyph - tbv_pkg::GLYPH_BUILTIN_BASE) < LP_BUILTIN);
        end else begin
            w_glyph_ok = (w_glyph - tbv_pkg::GLYPH_CUSTOM_BASE) < r_cfg.custom_glyph_count;
        end
    end

    // next state for one word
    always_comb begin
        n_left = r_left;
        n_pend = r_pend;
        n_high = r_high;
        n_seen = r_seen;
        n_err  = r_err;

        // running total, saturating
        if (i_q_item.first_of_archive) begin
            n_total = {{(tbv_pkg::TOTAL_W-1){1'b0}}, 1'b1};
        end else if (r_total != tbv_pkg::TOTAL_MAX) begin
            n_total = r_total + 1'b1;
        end else begin
            n_total = r_total;
        end

        if (n_err == tbv_pkg::ST_OK && n_total > r_cfg.byte_budget) begin
            n_err = tbv_pkg::ST_BUDGET;
        end

        // parse while no error and no terminator
        if (n_err == tbv_pkg::ST_OK && !r_seen) begin
            if (r_pend) begin
                n_pend = 1'b0;
                if (!w_glyph_ok) begin
                    n_err = tbv_pkg::ST_GLYPH;
                end
            end else if (r_left != 3'd0) begin
                n_left = r_left - 1'b1;
            end else begin
                case (i_q_item.kind)
                    tbv_pkg::K_TERM:    n_seen = 1'b1;
                    tbv_pkg::K_GLYPH: begin
                        n_pend = 1'b1;
                        n_high = i_q_item.code_byte;
                    end
                    tbv_pkg::K_UNKNOWN: n_err  = tbv_pkg::ST_UNKNOWN;
                    tbv_pkg::K_BRANCH:  n_err  = tbv_pkg::ST_BRANCH;
                    default:            n_left = i_q_item.extra_bytes;
                endcase
            end
        end

        // verdict on the last byte of a string
        if (!i_q_item.last_of_string || n_err != tbv_pkg::ST_OK) begin
            n_status = n_err;
        end else if (!n_seen && (n_pend || n_left != 3'd0)) begin
            n_status = tbv_pkg::ST_TRUNC;
        end else if (!n_seen) begin
            n_status = tbv_pkg::ST_NOTERM;
        end else begin
            n_status = tbv_pkg::ST_VALID;
        end

        // string state clears after its last byte
        if (i_q_item.last_of_string) begin
            n_left = 3'd0;
            n_pend = 1'b0;
            n_high = 8'd0;
            n_seen = 1'b0;
            n_err  = tbv_pkg::ST_OK;
        end
    end

    // state, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.custom_glyph_count <= 16'd0;
            r_cfg.byte_budget        <= tbv_pkg::BUDGET_RESET;
            r_left  <= 3'd0;
            r_pend  <= 1'b0;
            r_high  <= 8'd0;
            r_seen  <= 1'b0;
            r_err   <= tbv_pkg::ST_OK;
            r_total <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tbv_pkg::CFG_CUSTOM_COUNT: r_cfg.custom_glyph_count <= i_cfg_data[15:0];
                    tbv_pkg::CFG_BYTE_BUDGET:  r_cfg.byte_budget        <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_q_pop) begin
                r_left  <= n_left;
                r_pend  <= n_pend;
                r_high  <= n_high;
                r_seen  <= n_seen;
                r_err   <= n_err;
                r_total <= n_total;
                r_valid <= 1'b1;
                r_last  <= i_q_item.last_of_string;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status <= n_status;
        end
    end

    // a glyph low byte and instruction operands are never owed together
    a_pend_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_left == 3'd0))
        else $error("glyph pending while operand bytes owed");

    // after the terminator nothing is owed
    a_seen_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (!r_pend && r_left == 3'd0))
        else $error("instruction open after terminator");

    // verdict-only codes never stick as errors
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_err == tbv_pkg::ST_VALID || r_err == tbv_pkg::ST_TRUNC
          || r_err == tbv_pkg::ST_NOTERM))
        else $error("verdict code held as sticky error");

    // verdict codes only appear on the last byte of a string
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == tbv_pkg::ST_VALID || r_status == tbv_pkg::ST_TRUNC
                     || r_status == tbv_pkg::ST_NOTERM)) |-> r_last)
        else $error("string verdict on a non-final byte");

endmodule

### sv/text_bytecode_validator.sv
// Flow: an accepted word is written into the queue, and the back takes it from the queue
// head when the result register is free or draining; its result is then registered.
// Throughput: one byte per cycle unless results stall; parse state updates once per byte.
// A small queue between classifier and back lets input accept while a result waits.
// Reset is synchronous and active low: parse state, byte total and queue clear,
// custom glyph count goes to 0 and the byte budget to 4194304; no clearing pass.
module text_bytecode_validator #(
    parameter int unsigned BUILTIN_GLYPHS   = 287,
    parameter int unsigned QUEUE_DEPTH_LOG2 = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [22:0] i_cfg_data,
    // input words
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] code_byte
    input  logic        i_s_tlast,   // last_of_string
    input  logic        i_s_tuser,   // [0] first_of_archive
    // result words
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [2:0] status, [7:3] zero
    output logic        o_m_tlast    // string_end
);

    tbv_pkg::t_item w_push_item;
    tbv_pkg::t_item w_head_item;
    logic           w_push;
    logic           w_full;
    logic           w_head_valid;
    logic           w_pop;

    // classify incoming bytes
    tbv_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    // decoupling queue
    tbv_fifo #(
        .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_item  (w_head_item),
        .i_pop   (w_pop)
    );

    // parse, budget and result
    tbv_back #(
        .BUILTIN_GLYPHS (BUILTIN_GLYPHS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_head_valid),
        .i_q_item    (w_head_item),
        .o_q_pop     (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
